// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/cce_pkg.sv -----
// Package for the CRC engine: register indexes, select codes and bit helpers.
`default_nettype none

package cce_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WIDTH_SEL  = 3'd0,
    CFG_POLY       = 3'd1,
    CFG_INIT       = 3'd2,
    CFG_REFLECT_IN = 3'd3,
    CFG_REFLECT_OUT = 3'd4,
    CFG_XOR_OUT    = 3'd5,
    CFG_SIZE_SEL   = 3'd6
  } cfg_reg_e;

  // CRC width select codes (the unused codes mean the widest)
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;

  // Bytes-per-word select codes (the unused codes mean four)
  localparam logic [1:0] SIZE_1 = 2'd0;
  localparam logic [1:0] SIZE_2 = 2'd1;

  // Reset values of the configuration registers
  localparam logic [1:0]  RST_WIDTH_SEL = 2'd2;
  localparam logic [31:0] RST_POLY      = 32'h04C1_1DB7;
  localparam logic [31:0] RST_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_XOR_OUT   = 32'hFFFF_FFFF;
  localparam logic [1:0]  RST_SIZE_SEL  = 2'd0;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [31:0] reverse32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = v[31-i];
    return r;
  endfunction

  // One byte into a left-aligned CRC register: XOR into the top byte, then
  // eight MSB-first shift steps with the left-aligned polynomial.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_al,
                                           input logic [7:0]  data_byte,
                                           input logic [31:0] poly_al);
    logic [31:0] r;
    r = crc_al ^ {data_byte, 24'h0};
    for (int s = 0; s < 8; s++) begin
      if (r[31]) r = {r[30:0], 1'b0} ^ poly_al;
      else r = {r[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/configurable_crc_engine_top.sv -----
// Configurable CRC engine top level: config registers, input stage, CRC update, result register.
// A word marked last is registered in the input stage, then its CRC in the result register.
// Throughput: one word per cycle when not stalled; the byte-serial CRC update is one XOR network.
// A stall on the result side holds the input stage only when it carries a last word.
// Reset: config registers take their documented defaults, the pipeline empties.
`default_nettype none

module configurable_crc_engine_top #(
  parameter int unsigned MAX_CRC_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic        last_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      crc_value_o
);

  import cce_pkg::*;

  localparam int unsigned WMid = (MAX_CRC_WIDTH < 16) ? MAX_CRC_WIDTH : 16;
  localparam logic [5:0]  ShW8   = 6'(32 - 8);
  localparam logic [5:0]  ShWMid = 6'(32 - WMid);
  localparam logic [5:0]  ShWTop = 6'(32 - MAX_CRC_WIDTH);

  // Configuration registers
  logic [1:0]  width_sel_q;
  logic [31:0] poly_q;
  logic [31:0] init_q;
  logic        reflect_in_q;
  logic        reflect_out_q;
  logic [31:0] xor_out_q;
  logic [1:0]  size_sel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_sel_q   <= RST_WIDTH_SEL;
      poly_q        <= RST_POLY;
      init_q        <= RST_INIT;
      reflect_in_q  <= 1'b1;
      reflect_out_q <= 1'b1;
      xor_out_q     <= RST_XOR_OUT;
      size_sel_q    <= RST_SIZE_SEL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WIDTH_SEL:   width_sel_q   <= cfg_data_i[1:0];
        CFG_POLY:        poly_q        <= cfg_data_i;
        CFG_INIT:        init_q        <= cfg_data_i;
        CFG_REFLECT_IN:  reflect_in_q  <= cfg_data_i[0];
        CFG_REFLECT_OUT: reflect_out_q <= cfg_data_i[0];
        CFG_XOR_OUT:     xor_out_q     <= cfg_data_i;
        CFG_SIZE_SEL:    size_sel_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_data_q;
  logic        s1_last_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_crc_q, out_crc_d;
  logic        busy_q;
  logic [MAX_CRC_WIDTH-1:0] crc_q;
  logic        out_free, s1_fire, in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // CRC update on the registered word
  logic [5:0]  shamt;
  logic [31:0] wmask, start_crc, poly_al, crc_al, crc_r, crc_res;
  logic [3:0]  byte_en;
  logic [7:0]  cur_byte;

  always_comb begin
    case (width_sel_q)
      WSEL_8:  shamt = ShW8;
      WSEL_16: shamt = ShWMid;
      default: shamt = ShWTop;
    endcase
    case (size_sel_q)
      SIZE_1:  byte_en = 4'b0001;
      SIZE_2:  byte_en = 4'b0011;
      default: byte_en = 4'b1111;
    endcase
    wmask     = 32'hFFFF_FFFF >> shamt;
    start_crc = (busy_q ? 32'(crc_q) : init_q) & wmask;
    poly_al   = (poly_q & wmask) << shamt;
    crc_al    = start_crc << shamt;
    cur_byte  = 8'h00;
    // most significant selected byte goes first
    for (int k = 3; k >= 0; k--) begin
      if (byte_en[k]) begin
        cur_byte = s1_data_q[8*k +: 8];
        if (reflect_in_q) cur_byte = reverse8(cur_byte);
        crc_al = crc_byte(crc_al, cur_byte, poly_al);
      end
    end
    crc_r   = crc_al >> shamt;
    crc_res = ((reflect_out_q ? reverse32(crc_al) : crc_r) ^ xor_out_q) & wmask;
  end

  // Next state of the stages
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    out_crc_d   = out_crc_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
      out_crc_d   = crc_res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) busy_q <= !s1_last_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= data_word_i;
      s1_last_q <= last_i;
    end
    if (s1_fire) crc_q <= crc_r[MAX_CRC_WIDTH-1:0];
    out_crc_q <= out_crc_d;
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

  // Assertions
  `include "assert_macros.svh"

  `ASSERT_NXT(a_last_gives_result, s1_fire && s1_last_q, out_valid_q)
  `ASSERT_NXT(a_mid_word_sets_busy, s1_fire && !s1_last_q, busy_q)
  `ASSERT_NXT(a_last_clears_busy, s1_fire && s1_last_q, !busy_q)
  `ASSERT_IMP(a_mid_word_no_stall, s1_valid_q && !s1_last_q, !in_stall_o)

endmodule

`default_nettype wire
